// ===== hw/rtl/ipd_pkg.sv =====
`timescale 1ns / 1ps
package ipd_pkg;

   localparam int PARTICLES = 1024;
   localparam int IDX_W     = $clog2(PARTICLES);
   localparam int DIV_STEPS = 32;
   localparam int DIV_LAT   = DIV_STEPS + 1;
   localparam int ST_S9     = 2 * DIV_LAT + 7;
   localparam int PIPE_LAT  = ST_S9 + 2;

   localparam logic [16:0] ONE_Q16 = 17'h10000;

   typedef enum logic [1:0] {
      ACT_EXPL  = 2'd0,
      ACT_IMPL  = 2'd1,
      ACT_CLEAR = 2'd2,
      ACT_NONE  = 2'd3
   } act_type;

   localparam logic [1:0] CSR_USE_IMPLICIT = 2'd0;
   localparam logic [1:0] CSR_CN_ALPHA     = 2'd1;
   localparam logic [1:0] CSR_ADDED_MASS   = 2'd2;
   localparam logic [1:0] CSR_HALF_STEP    = 2'd3;

   typedef struct packed {
      act_type           act;
      logic [IDX_W-1:0]  idx;
      logic              impl;
      logic              expl;
      logic [31:0]       ksl;
      logic [2:0][31:0]  fl;
      logic [2:0][31:0]  v;
      logic [2:0][32:0]  u;
      logic [16:0]       a;
      logic [63:0]       dn;
      logic [63:0]       dd;
      logic [2:0][49:0]  bv;
      logic [2:0][32:0]  tmag;
      logic [2:0]        tn;
      logic [2:0][63:0]  p;
      logic [48:0]       ka;
      logic [2:0][63:0]  m;
      logic [2:0]        mn;
      logic [63:0]       d2;
      logic [2:0][31:0]  nv;
      logic [2:0][49:0]  anv;
      logic [2:0][32:0]  xmag;
      logic [2:0]        xneg;
      logic [2:0][64:0]  prod;
      logic [2:0][31:0]  drag;
   } item_type;

   typedef struct packed {
      logic              vld;
      act_type           act;
      logic [IDX_W-1:0]  idx;
      logic [2:0][31:0]  drag;
   } acc_req_type;

   function automatic logic [31:0] sat_signed(input logic neg, input logic [64:0] mag);
      logic [31:0] res;
      if (neg) begin
         if (mag >= 65'h0_8000_0000) res = 32'h8000_0000;
         else res = ~mag[31:0] + 32'd1;
      end else begin
         if (mag > 65'h0_7FFF_FFFF) res = 32'h7FFF_FFFF;
         else res = mag[31:0];
      end
      return res;
   endfunction

   function automatic logic [31:0] sat_add(input logic [31:0] x, input logic [31:0] y);
      logic [32:0] s;
      logic [31:0] res;
      s = {x[31], x} + {y[31], y};
      if (s[32] != s[31]) res = s[32] ? 32'h8000_0000 : 32'h7FFF_FFFF;
      else res = s[31:0];
      return res;
   endfunction

endpackage

// ===== hw/rtl/implicit_particle_drag_update.sv =====
`timescale 1ns / 1ps
// Per-particle drag kernel with a per-particle drag accumulator.
// Input channel req_*: one particle per transfer (action, index, ksl, fluid and
// particle velocity, mass). Result channel rsp_*: one result per input, in order,
// with the drag force, the new velocity and the accumulator row after the item.
// csr_*: write-only registers; the user must write them only while the block is
// idle; the block does not enforce this. Throughput: one item per cycle while
// the receiver does not stall; the 32-stage restoring dividers (drag gain, then
// velocity, one per axis) set the depth, the accumulator read-modify-write sits
// in the last two stages and bypasses the row written in the previous cycle, so
// repeated indices are exact. Reset: control registers go to their reset values
// and a clearing pass zeroes the accumulator store, one particle row per cycle;
// req_ready stays low during the pass.
// When the receiver stalls (rsp_valid high, rsp_ready low) the whole pipeline
// holds and req_ready drops in the same cycle; nothing is lost or repeated.
module implicit_particle_drag_update (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [1:0]         req_action,
   input  logic [9:0]         req_particle_index,
   input  logic [31:0]        req_ksl,
   input  logic signed [31:0] req_fluid_x,
   input  logic signed [31:0] req_fluid_y,
   input  logic signed [31:0] req_fluid_z,
   input  logic signed [31:0] req_vel_x,
   input  logic signed [31:0] req_vel_y,
   input  logic signed [31:0] req_vel_z,
   input  logic [31:0]        req_particle_mass,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [31:0] rsp_drag_x,
   output logic signed [31:0] rsp_drag_y,
   output logic signed [31:0] rsp_drag_z,
   output logic signed [31:0] rsp_new_vel_x,
   output logic signed [31:0] rsp_new_vel_y,
   output logic signed [31:0] rsp_new_vel_z,
   output logic signed [31:0] rsp_acc_x,
   output logic signed [31:0] rsp_acc_y,
   output logic signed [31:0] rsp_acc_z,
   input  logic               csr_wr_en,
   input  logic [1:0]         csr_index,
   input  logic [31:0]        csr_wdata
);
   import ipd_pkg::*;

   logic        use_impl_ff;
   logic [16:0] cn_alpha_ff;
   logic [31:0] amf_ff;
   logic [31:0] half_ff;

   logic                en;
   logic                accept;
   logic                busy;
   logic [PIPE_LAT-1:0] vld_ff;

   item_type s1_in, s1_ff;
   item_type dl1_in;
   item_type dl1_ff [0:DIV_LAT-1];
   item_type s3_in, s3_ff;
   item_type s4_in, s4_ff;
   item_type dl2_ff [0:DIV_LAT-1];
   item_type s5_in, s5_ff;
   item_type s6_in, s6_ff;
   item_type s7_in, s7_ff;
   item_type s8_in, s8_ff;
   item_type s9_in, s9_ff;

   logic [31:0]      k_quo;
   logic [2:0][31:0] nv_quo;
   acc_req_type      acc_req;
   logic [2:0][31:0] acc_new;

   logic [2:0][31:0] rsp_drag_ff;
   logic [2:0][31:0] rsp_nv_ff;
   logic [2:0][31:0] rsp_acc_ff;
   act_type          rsp_act_ff;

   assign en        = !vld_ff[PIPE_LAT-1] || rsp_ready;
   assign req_ready = en && !busy;
   assign accept    = req_valid && req_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         use_impl_ff <= 1'b0;
         cn_alpha_ff <= '0;
         amf_ff      <= 32'h0001_0000;
         half_ff     <= '0;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_USE_IMPLICIT: use_impl_ff <= csr_wdata[0];
            CSR_CN_ALPHA:     cn_alpha_ff <= csr_wdata[16:0];
            CSR_ADDED_MASS:   amf_ff      <= csr_wdata;
            CSR_HALF_STEP:    half_ff     <= csr_wdata;
         endcase
      end
   end

   // gain products, b*v, explicit difference
   always_comb begin
      logic [16:0] a_c;
      logic [16:0] b_c;
      s1_in      = '0;
      a_c        = (cn_alpha_ff > ONE_Q16) ? ONE_Q16 : cn_alpha_ff;
      b_c        = ONE_Q16 - a_c;
      s1_in.act  = act_type'(req_action);
      s1_in.idx  = req_particle_index;
      s1_in.impl = (s1_in.act == ACT_IMPL) && use_impl_ff;
      s1_in.expl = (s1_in.act == ACT_EXPL) && !use_impl_ff;
      s1_in.ksl  = req_ksl;
      s1_in.fl   = {req_fluid_z, req_fluid_y, req_fluid_x};
      s1_in.v    = {req_vel_z, req_vel_y, req_vel_x};
      s1_in.a    = a_c;
      s1_in.dn   = {32'd0, req_ksl} * {32'd0, half_ff};
      s1_in.dd   = {32'd0, req_particle_mass} * {32'd0, amf_ff};
      for (int j = 0; j < 3; j++) begin
         s1_in.bv[j] = 50'($signed({1'b0, b_c})) * 50'($signed(s1_in.v[j]));
         s1_in.u[j]  = 33'($signed(s1_in.fl[j])) - 33'($signed(s1_in.v[j]));
      end
   end

   // t = fluid - trunc(b*v / 2^16)
   always_comb begin
      logic signed [49:0] bvs;
      logic signed [49:0] bt;
      logic signed [51:0] tt;
      dl1_in = s1_ff;
      for (int j = 0; j < 3; j++) begin
         bvs            = $signed(s1_ff.bv[j]);
         bt             = (bvs + (bvs[49] ? 50'sd65535 : 50'sd0)) >>> 16;
         tt             = 52'($signed(s1_ff.fl[j])) - 52'(bt);
         dl1_in.tn[j]   = tt[51];
         dl1_in.tmag[j] = tt[51] ? 33'(-tt) : 33'(tt);
      end
   end

   ipd_div u_div_gain (
      .clock (clock),
      .en    (en),
      .num   (s1_ff.dn),
      .den   (s1_ff.dd),
      .quo   (k_quo)
   );

   always_comb begin
      s3_in = dl1_ff[DIV_LAT-1];
      for (int j = 0; j < 3; j++)
         s3_in.p[j] = {32'd0, k_quo} * {31'd0, s3_in.tmag[j]};
      s3_in.ka = 49'(k_quo) * 49'(s3_in.a);
   end

   // signed numerator v*2^16 + k*t as sign and saturated magnitude
   always_comb begin
      logic [31:0] vm;
      logic [63:0] qv;
      logic        vn;
      logic        pz;
      logic [64:0] sum;
      s4_in = s3_ff;
      for (int j = 0; j < 3; j++) begin
         vn = s3_ff.v[j][31];
         vm = vn ? (~s3_ff.v[j] + 32'd1) : s3_ff.v[j];
         qv = {16'd0, vm, 16'd0};
         pz = s3_ff.p[j] == 64'd0;
         sum = {1'b0, s3_ff.p[j]} + {1'b0, qv};
         if (pz || vm == 32'd0 || s3_ff.tn[j] == vn) begin
            s4_in.mn[j] = pz ? vn : s3_ff.tn[j];
            s4_in.m[j]  = sum[64] ? 64'hFFFF_FFFF_FFFF_FFFF : sum[63:0];
         end else if (s3_ff.p[j] >= qv) begin
            s4_in.mn[j] = s3_ff.tn[j];
            s4_in.m[j]  = s3_ff.p[j] - qv;
         end else begin
            s4_in.mn[j] = vn;
            s4_in.m[j]  = qv - s3_ff.p[j];
         end
      end
      s4_in.d2 = 64'h0000_0001_0000_0000 + 64'(s3_ff.ka);
   end

   for (genvar j = 0; j < 3; j++) begin : g_div_vel
      ipd_div u_div_vel (
         .clock (clock),
         .en    (en),
         .num   (s4_ff.m[j]),
         .den   (s4_ff.d2),
         .quo   (nv_quo[j])
      );
   end

   always_comb begin
      s5_in = dl2_ff[DIV_LAT-1];
      for (int j = 0; j < 3; j++)
         if (s5_in.impl) s5_in.nv[j] = sat_signed(s5_in.mn[j], {33'd0, nv_quo[j]});
         else s5_in.nv[j] = s5_in.v[j];
   end

   always_comb begin
      s6_in = s5_ff;
      for (int j = 0; j < 3; j++)
         s6_in.anv[j] = 50'($signed({1'b0, s5_ff.a})) * 50'($signed(s5_ff.nv[j]));
   end

   // velocity difference that drives the force, clamped to 2^32
   always_comb begin
      logic signed [50:0] sm;
      logic signed [50:0] st;
      logic signed [52:0] x;
      logic [52:0]        xm;
      s7_in = s6_ff;
      for (int j = 0; j < 3; j++) begin
         sm = 51'($signed(s6_ff.bv[j])) + 51'($signed(s6_ff.anv[j]));
         st = (sm + (sm[50] ? 51'sd65535 : 51'sd0)) >>> 16;
         if (s6_ff.impl) x = 53'($signed(s6_ff.fl[j])) - 53'(st);
         else if (s6_ff.expl) x = 53'($signed(s6_ff.u[j]));
         else x = '0;
         s7_in.xneg[j] = x[52];
         xm = x[52] ? 53'(-x) : 53'(x);
         s7_in.xmag[j] = (xm > 53'h1_0000_0000) ? 33'h1_0000_0000 : xm[32:0];
      end
   end

   always_comb begin
      s8_in = s7_ff;
      for (int j = 0; j < 3; j++)
         s8_in.prod[j] = {33'd0, s7_ff.ksl} * {32'd0, s7_ff.xmag[j]};
   end

   always_comb begin
      s9_in = s8_ff;
      for (int j = 0; j < 3; j++)
         s9_in.drag[j] = sat_signed(s8_ff.xneg[j], {16'd0, s8_ff.prod[j][64:16]});
   end

   assign acc_req.vld  = vld_ff[ST_S9];
   assign acc_req.act  = s9_ff.act;
   assign acc_req.idx  = s9_ff.idx;
   assign acc_req.drag = s9_ff.drag;

   ipd_acc u_acc (
      .clock  (clock),
      .reset  (reset),
      .en     (en),
      .rd_idx (s8_ff.idx),
      .wr     (acc_req),
      .acc    (acc_new),
      .busy   (busy)
   );

   always_ff @(posedge clock) begin
      if (en) begin
         s1_ff     <= s1_in;
         dl1_ff[0] <= dl1_in;
         for (int i = 1; i < DIV_LAT; i++) dl1_ff[i] <= dl1_ff[i-1];
         s3_ff     <= s3_in;
         s4_ff     <= s4_in;
         dl2_ff[0] <= s4_ff;
         for (int i = 1; i < DIV_LAT; i++) dl2_ff[i] <= dl2_ff[i-1];
         s5_ff       <= s5_in;
         s6_ff       <= s6_in;
         s7_ff       <= s7_in;
         s8_ff       <= s8_in;
         s9_ff       <= s9_in;
         rsp_drag_ff <= s9_ff.drag;
         rsp_nv_ff   <= s9_ff.nv;
         rsp_acc_ff  <= acc_new;
         rsp_act_ff  <= s9_ff.act;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[PIPE_LAT-2:0], accept};
      end
   end

   assign rsp_valid     = vld_ff[PIPE_LAT-1];
   assign rsp_drag_x    = rsp_drag_ff[0];
   assign rsp_drag_y    = rsp_drag_ff[1];
   assign rsp_drag_z    = rsp_drag_ff[2];
   assign rsp_new_vel_x = rsp_nv_ff[0];
   assign rsp_new_vel_y = rsp_nv_ff[1];
   assign rsp_new_vel_z = rsp_nv_ff[2];
   assign rsp_acc_x     = rsp_acc_ff[0];
   assign rsp_acc_y     = rsp_acc_ff[1];
   assign rsp_acc_z     = rsp_acc_ff[2];

   a_no_accept_while_clearing: assert property (@(posedge clock) disable iff (reset)
      busy |-> !req_ready)
      else $error("input accepted during accumulator clear");

   a_clear_reads_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_act_ff == ACT_CLEAR) |-> (rsp_acc_ff == '0))
      else $error("clear result shows nonzero accumulator");

   a_no_force_outside_phase: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_act_ff == ACT_CLEAR || rsp_act_ff == ACT_NONE))
      |-> (rsp_drag_ff == '0))
      else $error("drag force on clear or unused action");

   a_empty_after_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid right after reset");

endmodule

// ===== hw/rtl/ipd_div.sv =====
`timescale 1ns / 1ps
module ipd_div (
   input  logic        clock,
   input  logic        en,
   input  logic [63:0] num,
   input  logic [63:0] den,
   output logic [31:0] quo
);
   import ipd_pkg::*;

   // floor(num * 2^16 / den), saturated to 32 bits; one quotient bit per stage
   logic [63:0] rem_ff [0:DIV_STEPS];
   logic [63:0] den_ff [0:DIV_STEPS];
   logic [15:0] low_ff [0:DIV_STEPS];
   logic [31:0] quo_ff [0:DIV_STEPS];
   logic        ovf_ff [0:DIV_STEPS];

   logic [63:0] rem_in [0:DIV_STEPS-1];
   logic [31:0] quo_in [0:DIV_STEPS-1];
   logic        ovf_in;

   assign ovf_in = {16'd0, num} >= {den, 16'd0};

   always_comb begin
      logic [64:0] trial;
      for (int i = 0; i < DIV_STEPS; i++) begin
         trial = {rem_ff[i], low_ff[i][15]};
         if (trial >= {1'b0, den_ff[i]}) begin
            rem_in[i] = 64'(trial - {1'b0, den_ff[i]});
            quo_in[i] = {quo_ff[i][30:0], 1'b1};
         end else begin
            rem_in[i] = trial[63:0];
            quo_in[i] = {quo_ff[i][30:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff[0] <= {16'd0, num[63:16]};
         den_ff[0] <= den;
         low_ff[0] <= num[15:0];
         quo_ff[0] <= '0;
         ovf_ff[0] <= ovf_in;
         for (int i = 0; i < DIV_STEPS; i++) begin
            rem_ff[i+1] <= rem_in[i];
            quo_ff[i+1] <= quo_in[i];
            den_ff[i+1] <= den_ff[i];
            low_ff[i+1] <= {low_ff[i][14:0], 1'b0};
            ovf_ff[i+1] <= ovf_ff[i];
         end
      end
   end

   assign quo = ovf_ff[DIV_STEPS] ? 32'hFFFF_FFFF : quo_ff[DIV_STEPS];

endmodule

// ===== hw/rtl/ipd_acc.sv =====
`timescale 1ns / 1ps
module ipd_acc (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       en,
   input  logic [ipd_pkg::IDX_W-1:0]  rd_idx,
   input  ipd_pkg::acc_req_type       wr,
   output logic [2:0][31:0]           acc,
   output logic                       busy
);
   import ipd_pkg::*;

   logic [95:0]      mem [0:PARTICLES-1];
   logic [95:0]      rd_ff;
   logic             busy_ff;
   logic [IDX_W-1:0] clr_cnt_ff;
   logic             fwd_vld_ff;
   logic [IDX_W-1:0] fwd_idx_ff;
   logic [95:0]      fwd_val_ff;
   logic [95:0]      old_row;
   logic [95:0]      new_row;
   logic             wr_do;

   // the row written in the same cycle as this item's read is taken from the bypass
   assign old_row = (fwd_vld_ff && fwd_idx_ff == wr.idx) ? fwd_val_ff : rd_ff;

   always_comb begin
      unique case (wr.act)
         ACT_CLEAR: new_row = '0;
         ACT_NONE:  new_row = old_row;
         ACT_EXPL, ACT_IMPL: begin
            for (int j = 0; j < 3; j++)
               new_row[j*32 +: 32] = sat_add(old_row[j*32 +: 32], wr.drag[j]);
         end
      endcase
   end

   assign wr_do = en && wr.vld && wr.act != ACT_NONE;

   always_ff @(posedge clock) begin
      if (busy_ff) begin
         mem[clr_cnt_ff] <= '0;
      end else if (wr_do) begin
         mem[wr.idx] <= new_row;
      end
      if (en) begin
         rd_ff      <= mem[rd_idx];
         fwd_idx_ff <= wr.idx;
         fwd_val_ff <= new_row;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff    <= 1'b1;
         clr_cnt_ff <= '0;
         fwd_vld_ff <= 1'b0;
      end else begin
         if (busy_ff) begin
            clr_cnt_ff <= clr_cnt_ff + 1'b1;
            busy_ff    <= clr_cnt_ff != IDX_W'(PARTICLES - 1);
         end
         if (en) fwd_vld_ff <= wr_do;
      end
   end

   for (genvar j = 0; j < 3; j++) begin : g_out
      assign acc[j] = new_row[j*32 +: 32];
   end
   assign busy = busy_ff;

endmodule

// ===== bench/implicit_particle_drag_update_tb.sv =====
`timescale 1ns / 1ps
module implicit_particle_drag_update_tb;
   import ipd_pkg::*;

   localparam int CYCLE_LIMIT = 300000;

   typedef struct {
      act_type                 act;
      logic [9:0]              idx;
      logic [31:0]             ksl;
      logic [31:0]             mass;
      logic signed [31:0]      fl[3];
      logic signed [31:0]      v[3];
   } particle_req_t;

   // drag x/y/z, new velocity x/y/z, accumulator x/y/z
   typedef struct {
      logic signed [31:0]      f[9];
   } drag_rsp_t;

   class drag_scoreboard;
      drag_rsp_t   pending_q[$];
      int          acc[3 * PARTICLES];
      bit          use_impl;
      logic [16:0] alpha;
      logic [31:0] amass;
      logic [31:0] hstep;
      int          errors;

      function new();
         foreach (acc[i]) acc[i] = 0;
         use_impl = 0;
         alpha = 0;
         amass = 32'h0001_0000;
         hstep = 0;
         errors = 0;
      endfunction

      function void set_reg(logic [1:0] idx, logic [31:0] val);
         case (idx)
            CSR_USE_IMPLICIT: use_impl = val[0];
            CSR_CN_ALPHA:     alpha = val[16:0];
            CSR_ADDED_MASS:   amass = val;
            CSR_HALF_STEP:    hstep = val;
            default: ;
         endcase
      endfunction

      function logic [31:0] sat32(bit neg, logic [95:0] mag);
         if (neg) return (mag >= 96'h8000_0000) ? 32'h8000_0000 : -mag[31:0];
         return (mag > 96'h7FFF_FFFF) ? 32'h7FFF_FFFF : mag[31:0];
      endfunction

      function logic [31:0] div16(logic [63:0] n, logic [63:0] d);
         logic [79:0] qq;
         if (d == 0) return 32'hFFFF_FFFF;
         qq = {n, 16'h0} / {16'h0, d};
         return (qq > 80'hFFFF_FFFF) ? 32'hFFFF_FFFF : qq[31:0];
      endfunction

      function logic [31:0] force_of(logic [31:0] k, longint x);
         bit          neg;
         logic [95:0] m;
         neg = x < 0;
         m = neg ? 96'(-x) : 96'(x);
         if (m > 96'h1_0000_0000) m = 96'h1_0000_0000;
         return sat32(neg, (96'(k) * m) >> 16);
      endfunction

      function void note_transfer(particle_req_t r);
         drag_rsp_t        e;
         longint           a, b, t, du, s;
         logic [31:0]      k;
         logic [63:0]      d, p, q, m;
         logic [64:0]      sum;
         bit               tn, vn, neg;
         int               base;
         base = 3 * (int'(r.idx) % PARTICLES);
         for (int j = 0; j < 3; j++) begin
            e.f[j] = 0;
            e.f[3 + j] = r.v[j];
         end
         if (r.act == ACT_EXPL && !use_impl) begin
            for (int j = 0; j < 3; j++)
               e.f[j] = force_of(r.ksl, longint'(r.fl[j]) - longint'(r.v[j]));
         end else if (r.act == ACT_IMPL && use_impl) begin
            a = (alpha > 17'h10000) ? 65536 : longint'(alpha);
            b = 65536 - a;
            k = div16(64'(r.ksl) * 64'(hstep), 64'(r.mass) * 64'(amass));
            d = 64'h1_0000_0000 + 64'(k) * 64'(a);
            for (int j = 0; j < 3; j++) begin
               t = longint'(r.fl[j]) - (b * longint'(r.v[j])) / 65536;
               tn = t < 0;
               p = 64'(k) * 64'(tn ? -t : t);
               vn = r.v[j] < 0;
               q = 64'(vn ? -longint'(r.v[j]) : longint'(r.v[j])) << 16;
               if (p == 0 || q == 0 || tn == vn) begin
                  neg = (p != 0) ? tn : vn;
                  sum = {1'b0, p} + {1'b0, q};
                  m = sum[64] ? '1 : sum[63:0];
               end else if (p >= q) begin
                  neg = tn;
                  m = p - q;
               end else begin
                  neg = vn;
                  m = q - p;
               end
               e.f[3 + j] = sat32(neg, 96'(div16(m, d)));
               du = longint'(r.fl[j])
                  - (b * longint'(r.v[j]) + a * longint'(e.f[3 + j])) / 65536;
               e.f[j] = force_of(r.ksl, du);
            end
         end
         for (int j = 0; j < 3; j++) begin
            if (r.act == ACT_CLEAR) begin
               acc[base + j] = 0;
            end else if (r.act != ACT_NONE) begin
               s = longint'(acc[base + j]) + longint'(e.f[j]);
               if (s > 64'sd2147483647) s = 64'sd2147483647;
               if (s < -64'sd2147483648) s = -64'sd2147483648;
               acc[base + j] = int'(s);
            end
            e.f[6 + j] = acc[base + j];
         end
         pending_q.push_back(e);
      endfunction

      function void check_result(drag_rsp_t got);
         drag_rsp_t e;
         string     names[9];
         names = '{"drag_x", "drag_y", "drag_z", "new_vel_x", "new_vel_y", "new_vel_z",
                   "acc_x", "acc_y", "acc_z"};
         if (pending_q.size() == 0) begin
            errors++;
            if (errors <= 10) $display("result transfer with nothing expected");
            return;
         end
         e = pending_q.pop_front();
         for (int i = 0; i < 9; i++)
            if (got.f[i] !== e.f[i]) begin
               errors++;
               if (errors <= 10)
                  $display("%s mismatch: expected %h, got %h", names[i], e.f[i], got.f[i]);
            end
      endfunction
   endclass

   logic               clock = 0;
   logic               reset = 1;
   logic               req_valid = 0;
   logic               req_ready;
   logic [1:0]         req_action = 0;
   logic [9:0]         req_particle_index = 0;
   logic [31:0]        req_ksl = 0;
   logic signed [31:0] req_fluid_x = 0, req_fluid_y = 0, req_fluid_z = 0;
   logic signed [31:0] req_vel_x = 0, req_vel_y = 0, req_vel_z = 0;
   logic [31:0]        req_particle_mass = 1;
   logic               rsp_valid;
   logic               rsp_ready = 0;
   logic signed [31:0] rsp_drag_x, rsp_drag_y, rsp_drag_z;
   logic signed [31:0] rsp_new_vel_x, rsp_new_vel_y, rsp_new_vel_z;
   logic signed [31:0] rsp_acc_x, rsp_acc_y, rsp_acc_z;
   logic               csr_wr_en = 0;
   logic [1:0]         csr_index = 0;
   logic [31:0]        csr_wdata = 0;

   drag_scoreboard sb = new();
   bit             send_burst = 0;
   bit             recv_burst = 0;
   int             cycles = 0;

   implicit_particle_drag_update dut (.*);

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("implicit_particle_drag_update_tb: errors");
         $finish;
      end
   end

   task automatic csr_write(logic [1:0] idx, logic [31:0] val);
      csr_wr_en <= 1;
      csr_index <= idx;
      csr_wdata <= val;
      sb.set_reg(idx, val);
      @(negedge clock);
   endtask

   task automatic set_regs(bit impl, logic [31:0] al, logic [31:0] am, logic [31:0] hs);
      csr_write(CSR_USE_IMPLICIT, {31'b0, impl});
      csr_write(CSR_CN_ALPHA, al);
      csr_write(CSR_ADDED_MASS, am);
      csr_write(CSR_HALF_STEP, hs);
      csr_wr_en <= 0;
      @(negedge clock);
   endtask

   task automatic send(particle_req_t r);
      int gap;
      gap = send_burst ? 0 : $urandom_range(0, 5);
      if (gap > 0) begin
         req_valid <= 0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1;
      req_action <= r.act;
      req_particle_index <= r.idx;
      req_ksl <= r.ksl;
      req_particle_mass <= r.mass;
      req_fluid_x <= r.fl[0];
      req_fluid_y <= r.fl[1];
      req_fluid_z <= r.fl[2];
      req_vel_x <= r.v[0];
      req_vel_y <= r.v[1];
      req_vel_z <= r.v[2];
      do @(posedge clock); while (!req_ready);
      sb.note_transfer(r);
      @(negedge clock);
   endtask

   task automatic drain();
      req_valid <= 0;
      while (sb.pending_q.size() != 0) @(negedge clock);
   endtask

   function automatic logic [31:0] rand_word();
      case ($urandom_range(0, 4))
         0: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
         1: return $urandom_range(0, 2 ** 20) - 2 ** 19;
         2: return $urandom_range(0, 2 ** 24) - 2 ** 23;
         default: return $urandom;
      endcase
   endfunction

   function automatic particle_req_t rand_req(bit impl);
      particle_req_t r;
      int            sel;
      sel = $urandom_range(0, 19);
      if (sel < 16) r.act = impl ? ACT_IMPL : ACT_EXPL;
      else if (sel == 16) r.act = impl ? ACT_EXPL : ACT_IMPL;
      else if (sel == 17) r.act = ACT_CLEAR;
      else if (sel == 18) r.act = ACT_NONE;
      else r.act = act_type'($urandom_range(0, 3));
      r.idx = $urandom_range(0, 3) == 0 ? 10'($urandom) : 10'($urandom_range(0, 15));
      r.ksl = $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 2 ** 20);
      r.mass = $urandom_range(0, 2) == 0 ? $urandom : $urandom_range(1, 2 ** 20);
      if (r.mass == 0) r.mass = 1;
      for (int j = 0; j < 3; j++) begin
         r.fl[j] = rand_word();
         r.v[j] = rand_word();
      end
      return r;
   endfunction

   function automatic particle_req_t mk(act_type act, logic [9:0] idx, logic [31:0] ksl,
                                        logic [31:0] fl, logic [31:0] v, logic [31:0] mass);
      particle_req_t r;
      r.act = act;
      r.idx = idx;
      r.ksl = ksl;
      r.mass = mass;
      for (int j = 0; j < 3; j++) begin
         r.fl[j] = fl;
         r.v[j] = v;
      end
      r.fl[1] = -fl;
      r.v[2] = -v;
      return r;
   endfunction

   task automatic random_phase(bit impl, int count);
      for (int i = 0; i < count; i++) begin
         if (i % 40 == 0) begin
            send_burst = ($urandom_range(0, 3) == 0);
            recv_burst = ($urandom_range(0, 3) == 0);
         end
         send(rand_req(impl));
      end
      send_burst = 0;
      recv_burst = 0;
      drain();
   endtask

   initial begin
      drag_rsp_t got;
      int        stall;
      forever begin
         stall = recv_burst ? 0 : $urandom_range(0, 5);
         if (stall > 0) begin
            rsp_ready <= 0;
            repeat (stall) @(negedge clock);
         end
         rsp_ready <= 1;
         do @(posedge clock); while (reset || !rsp_valid);
         got.f = '{rsp_drag_x, rsp_drag_y, rsp_drag_z, rsp_new_vel_x, rsp_new_vel_y,
                   rsp_new_vel_z, rsp_acc_x, rsp_acc_y, rsp_acc_z};
         sb.check_result(got);
         @(negedge clock);
      end
   end

   initial begin
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 0;
      @(negedge clock);

      // reset register values: explicit drag, plus implicit, unused and clear actions
      send(mk(ACT_EXPL, 10'd0, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h1));
      send(mk(ACT_EXPL, 10'd0, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h1));
      send(mk(ACT_EXPL, 10'd1023, 32'd0, 32'h1234_5678, 32'hF000_0000, 32'hFFFF_FFFF));
      send(mk(ACT_EXPL, 10'd1023, 32'h0001_8000, 32'h0003_0000, 32'h0001_0000, 32'h10000));
      send(mk(ACT_IMPL, 10'd1023, 32'h0001_0000, 32'h0005_0000, 32'h0002_0000, 32'h10000));
      send(mk(ACT_NONE, 10'd0, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h0, 32'h1));
      send(mk(ACT_CLEAR, 10'd0, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h0, 32'h1));
      send(mk(ACT_EXPL, 10'd0, 32'h0000_0001, 32'h0000_0001, 32'hFFFF_FFFF, 32'h1));
      drain();
      set_regs(1, 32'h8000, 32'h0001_0000, 32'h0001_0000);
      send(mk(ACT_IMPL, 10'd5, 32'h0002_0000, 32'h0004_0000, 32'h0001_0000, 32'h10000));
      send(mk(ACT_IMPL, 10'd5, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h1));
      send(mk(ACT_IMPL, 10'd5, 32'd0, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF));
      send(mk(ACT_EXPL, 10'd5, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h1));
      send(mk(ACT_IMPL, 10'd1023, 32'h0000_8000, 32'hFFFF_0000, 32'h0000_4000, 32'h20000));
      send(mk(ACT_CLEAR, 10'd5, 32'h0, 32'h0, 32'h0, 32'h1));
      drain();
      set_regs(1, 32'h1FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send(mk(ACT_IMPL, 10'd7, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h1));
      send(mk(ACT_IMPL, 10'd7, 32'h0003_0000, 32'h0001_0000, 32'hFFFF_0000, 32'h8000));
      random_phase(1, 120);

      set_regs(1, 32'h0, 32'h0001_0000, 32'h0000_4000);
      random_phase(1, 150);
      set_regs(1, 32'h10000, 32'h0001_0000 + $urandom_range(0, 2 ** 18), $urandom);
      random_phase(1, 150);
      set_regs(1, $urandom_range(0, 32'h1FFFF), 32'h0001_0000 + $urandom_range(0, 2 ** 20),
               $urandom_range(0, 2 ** 18));
      random_phase(1, 150);
      set_regs(0, $urandom, $urandom | 32'h0001_0000, $urandom);
      random_phase(0, 150);

      repeat (PIPE_LAT + 20) @(negedge clock);
      if (sb.errors == 0 && sb.pending_q.size() == 0)
         $display("implicit_particle_drag_update_tb: clean");
      else
         $display("implicit_particle_drag_update_tb: errors");
      $finish;
   end

endmodule
